[hdl/ffa_pkg.sv]
package ffa_pkg;

	localparam int ADDR_W = 21;
	localparam int HDR_W = 7;
	localparam int STAT_W = 2;
	localparam logic [HDR_W-1:0] HDR_RESET = 7'd24;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd2;
	localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd3;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_FREE_NEXT,
		ST_FREE_PREV,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_BUILD,
		CMD_SET_USED,
		CMD_SET_FREE,
		CMD_INSERT,
		CMD_DELETE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic [ADDR_W-1:0] new_start;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic used;
		logic [ADDR_W-1:0] start;
	} cell_t;

	typedef struct packed {
		logic alloc_hit;
		logic free_hit;
		logic exact;
		logic used;
		logic prev_free;
		logic next_free;
		logic [ADDR_W-1:0] start;
	} hit_t;

endpackage

[hdl/ffa_cell.sv]
module ffa_cell
	import ffa_pkg::*;
#(
	parameter int IDX = 0,
	parameter int IW = 6,
	parameter int CW = 7,
	parameter logic [ADDR_W-1:0] HEAP_END = '0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [IW-1:0]     pos,
	input  logic [CW-1:0]     scan,
	input  logic [ADDR_W-1:0] req,
	input  logic [HDR_W-1:0]  hdr,
	input  logic [ADDR_W-1:0] addr,
	input  cell_t             prev,
	input  cell_t             next,
	output cell_t             cur,
	output hit_t              hit
);

	logic [ADDR_W-1:0] end_w;
	logic [ADDR_W-1:0] len;
	logic [ADDR_W-1:0] psz;
	logic [ADDR_W:0]   need;
	logic              sel;
	logic              fit_exact;
	logic              fit_split;
	logic [IW:0]       pos_x;
	logic [IW:0]       idx_c;
	cell_t             nxt;

	assign end_w = next.valid ? next.start : HEAP_END;
	assign len = end_w - cur.start;
	assign psz = (len > ADDR_W'(hdr)) ? (len - ADDR_W'(hdr)) : '0;
	assign need = {1'b0, req} + (ADDR_W + 1)'(hdr);
	assign fit_exact = (psz == req);
	assign fit_split = ({1'b0, psz} > need);
	assign sel = (scan == CW'(IDX));
	assign pos_x = {1'b0, pos};
	assign idx_c = (IW + 1)'(IDX);

	always_comb begin
		hit = '0;
		if (sel) begin
			hit.alloc_hit = cur.valid && !cur.used && (fit_exact || fit_split);
			hit.free_hit = cur.valid
				&& (({1'b0, cur.start} + (ADDR_W + 1)'(hdr)) == {1'b0, addr});
			hit.exact = fit_exact;
			hit.used = cur.used;
			hit.prev_free = prev.valid && !prev.used;
			hit.next_free = next.valid && !next.used;
			hit.start = cur.start;
		end
	end

	always_comb begin
		nxt = cur;
		unique case (cmd.op)
			CMD_NONE: begin
			end
			CMD_BUILD: begin
				nxt.valid = (IDX == 0);
				nxt.used = 1'b0;
				nxt.start = '0;
			end
			CMD_SET_USED: begin
				if (idx_c == pos_x) nxt.used = 1'b1;
			end
			CMD_SET_FREE: begin
				if (idx_c == pos_x) nxt.used = 1'b0;
			end
			CMD_INSERT: begin
				priority if (idx_c == pos_x) begin
					nxt.used = 1'b1;
				end else if (idx_c == pos_x + 1'b1) begin
					nxt.valid = 1'b1;
					nxt.used = 1'b0;
					nxt.start = cmd.new_start;
				end else if (idx_c > pos_x + 1'b1) begin
					nxt = prev;
				end else begin
					nxt = cur;
				end
			end
			CMD_DELETE: begin
				if (idx_c >= pos_x) nxt = next;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur <= '0;
		end else begin
			cur <= nxt;
		end
	end

endmodule

[hdl/first_fit_heap_allocator_unit.sv]
// First-fit heap allocator. Each request on the input channel is either an
// allocate (func 0, req_size bytes) or a free (func 1, payload address).
// Exactly one result leaves on the output channel per request: a status and,
// for a successful allocate, the granted payload offset.
// The heap is held as a row of cells, one per block, in address order. A
// request scans the cells one per cycle, from the first block until a fit,
// the freed block or the end of the row is found; the result is then
// registered and loaded into the output register. The first request after
// reset first builds the row, and a successful free then merges the block
// with the next and then the previous block where those are free.
// One request is worked on at a time; a new request is taken as soon as the
// previous result sits in the output register.
// Reset clears the block row, so the first request builds one free block
// spanning the heap. The header size register comes out of reset at 24.
// While the receiver stalls, the result holds in the output register and a
// following request runs until its own result is ready, then waits.
module first_fit_heap_allocator_unit
	import ffa_pkg::*;
#(
	parameter int HEAP_BYTES = 1048576,
	parameter int MAX_BLOCKS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [HDR_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [ADDR_W-1:0] req_size,
	input  logic [ADDR_W-1:0] address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic [ADDR_W-1:0] payload_offset
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [ADDR_W-1:0] HEAP_END = ADDR_W'(HEAP_BYTES);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BLOCKS);

	state_t            state_q, state_nxt;
	logic [HDR_W-1:0]  hdr_q;
	logic              ready_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     scan_q;
	logic [IW-1:0]     pos_q;
	logic              func_q;
	logic [ADDR_W-1:0] req_q;
	logic [ADDR_W-1:0] addr_q;
	logic              nf_q;
	logic              pf_q;
	logic [STAT_W-1:0] res_stat_q;
	logic [ADDR_W-1:0] res_ofs_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [ADDR_W-1:0] payload_offset_q;

	cmd_t              cmd;
	logic [IW-1:0]     cmd_pos;
	cell_t             cells [MAX_BLOCKS];
	hit_t              hits [MAX_BLOCKS];
	hit_t              hit_any;
	logic              scan_end;
	logic              out_load;

	genvar k;
	generate
		for (k = 0; k < MAX_BLOCKS; k++) begin : g_cell
			cell_t prev_c;
			cell_t next_c;
			if (k == 0) begin : g_first
				assign prev_c = '0;
			end else begin : g_mid
				assign prev_c = cells[k-1];
			end
			if (k == MAX_BLOCKS - 1) begin : g_last
				assign next_c = '0;
			end else begin : g_rest
				assign next_c = cells[k+1];
			end
			ffa_cell #(
				.IDX(k),
				.IW(IW),
				.CW(CW),
				.HEAP_END(HEAP_END)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cmd(cmd),
				.pos(cmd_pos),
				.scan(scan_q),
				.req(req_q),
				.hdr(hdr_q),
				.addr(addr_q),
				.prev(prev_c),
				.next(next_c),
				.cur(cells[k]),
				.hit(hits[k])
			);
		end
	endgenerate

	always_comb begin
		hit_any = '0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			hit_any = hit_any | hits[i];
		end
	end

	assign scan_end = (scan_q == count_q);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ready_q ? ST_SCAN : ST_INIT;
			end
			ST_INIT: state_nxt = ST_SCAN;
			ST_SCAN: begin
				priority if (scan_end) begin
					state_nxt = ST_DONE;
				end else if (func_q == FUNC_ALLOC && hit_any.alloc_hit) begin
					state_nxt = ST_DONE;
				end else if (func_q == FUNC_FREE && hit_any.free_hit) begin
					state_nxt = hit_any.used ? ST_FREE_NEXT : ST_DONE;
				end else begin
					state_nxt = ST_SCAN;
				end
			end
			ST_FREE_NEXT: state_nxt = ST_FREE_PREV;
			ST_FREE_PREV: state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_load) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = CMD_NONE;
		cmd.new_start = hit_any.start + ADDR_W'(hdr_q) + req_q;
		cmd_pos = scan_q[IW-1:0];
		unique case (state_q)
			ST_INIT: cmd.op = CMD_BUILD;
			ST_SCAN: begin
				priority if (scan_end) begin
					cmd.op = CMD_NONE;
				end else if (func_q == FUNC_ALLOC && hit_any.alloc_hit) begin
					priority if (hit_any.exact) cmd.op = CMD_SET_USED;
					else if (count_q != COUNT_MAX) cmd.op = CMD_INSERT;
					else cmd.op = CMD_NONE;
				end else if (func_q == FUNC_FREE && hit_any.free_hit && hit_any.used) begin
					cmd.op = CMD_SET_FREE;
				end else begin
					cmd.op = CMD_NONE;
				end
			end
			ST_FREE_NEXT: begin
				cmd_pos = pos_q + 1'b1;
				if (nf_q) cmd.op = CMD_DELETE;
			end
			ST_FREE_PREV: begin
				cmd_pos = pos_q;
				if (pf_q) cmd.op = CMD_DELETE;
			end
			default: cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hdr_q <= HDR_RESET;
			ready_q <= 1'b0;
			count_q <= '0;
			scan_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) hdr_q <= cfg_wr_data;
			if (state_q == ST_INIT) ready_q <= 1'b1;
			unique case (cmd.op)
				CMD_BUILD: count_q <= CW'(1);
				CMD_INSERT: count_q <= count_q + 1'b1;
				CMD_DELETE: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
			if (state_q == ST_IDLE) scan_q <= '0;
			else if (state_q == ST_SCAN && state_nxt == ST_SCAN) scan_q <= scan_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q <= func;
			req_q <= req_size;
			addr_q <= address;
		end
		if (state_q == ST_SCAN) begin
			pos_q <= scan_q[IW-1:0];
			nf_q <= hit_any.next_free;
			pf_q <= hit_any.prev_free;
			res_ofs_q <= '0;
			priority if (scan_end) begin
				res_stat_q <= (func_q == FUNC_FREE) ? STAT_BAD_ADDR : STAT_NO_SPACE;
			end else if (func_q == FUNC_ALLOC && hit_any.alloc_hit) begin
				if (!hit_any.exact && count_q == COUNT_MAX) begin
					res_stat_q <= STAT_TABLE_FULL;
				end else begin
					res_stat_q <= STAT_OK;
					res_ofs_q <= hit_any.start + ADDR_W'(hdr_q);
				end
			end else if (func_q == FUNC_FREE && hit_any.free_hit) begin
				res_stat_q <= hit_any.used ? STAT_OK : STAT_BAD_ADDR;
			end else begin
				res_stat_q <= res_stat_q;
			end
		end
		if (out_load) begin
			status_q <= res_stat_q;
			payload_offset_q <= res_ofs_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign payload_offset = payload_offset_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("Block count exceeds the table size.");
	a_first_block: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q && state_q == ST_IDLE |-> cells[0].valid && cells[0].start == '0)
		else $error("First block does not start the heap.");
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CMD_INSERT |-> count_q < COUNT_MAX)
		else $error("Split issued with a full table.");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != ST_IDLE)
		else $error("Accepted request did not start.");
`endif

endmodule

[verif/heap_checker.sv]
`timescale 1ns / 100ps

module heap_checker
	import ffa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [HDR_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              func,
	input  logic [ADDR_W-1:0] req_size,
	input  logic [ADDR_W-1:0] address,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [STAT_W-1:0] status,
	input  logic [ADDR_W-1:0] payload_offset,
	output int                fail_count,
	output int                pending
);

	localparam int HEAP = 1048576;
	localparam int SLOTS = 64;

	typedef struct {
		logic [STAT_W-1:0] stat;
		logic [ADDR_W-1:0] ofs;
	} outcome_t;

	outcome_t outcome_q[$];

	longint unsigned blk_lo[SLOTS];
	longint unsigned blk_hi[SLOTS];
	bit blk_used[SLOTS];
	int blk_cnt;
	bit heap_built;
	logic [HDR_W-1:0] hdr;

	assign pending = outcome_q.size();

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic longint unsigned payload_len(input int i);
		longint unsigned len;
		len = blk_hi[i] - blk_lo[i];
		return (len > hdr) ? len - hdr : 0;
	endfunction

	function automatic void drop_slot(input int i);
		for (int k = i; k + 1 < blk_cnt; k++) begin
			blk_lo[k] = blk_lo[k + 1];
			blk_hi[k] = blk_hi[k + 1];
			blk_used[k] = blk_used[k + 1];
		end
		blk_cnt--;
	endfunction

	function automatic outcome_t run_alloc(input longint unsigned req);
		outcome_t res;
		longint unsigned psz;
		res.stat = STAT_NO_SPACE;
		res.ofs = '0;
		for (int i = 0; i < blk_cnt; i++) begin
			if (blk_used[i])
				continue;
			psz = payload_len(i);
			if (psz == req) begin
				blk_used[i] = 1;
				res.stat = STAT_OK;
				res.ofs = ADDR_W'(blk_lo[i] + hdr);
				return res;
			end
			if (psz > req + hdr) begin
				if (blk_cnt >= SLOTS) begin
					res.stat = STAT_TABLE_FULL;
					return res;
				end
				for (int k = blk_cnt; k > i + 1; k--) begin
					blk_lo[k] = blk_lo[k - 1];
					blk_hi[k] = blk_hi[k - 1];
					blk_used[k] = blk_used[k - 1];
				end
				blk_cnt++;
				blk_lo[i + 1] = blk_lo[i] + hdr + req;
				blk_hi[i + 1] = blk_hi[i];
				blk_used[i + 1] = 0;
				blk_hi[i] = blk_lo[i + 1];
				blk_used[i] = 1;
				res.stat = STAT_OK;
				res.ofs = ADDR_W'(blk_lo[i] + hdr);
				return res;
			end
		end
		return res;
	endfunction

	function automatic outcome_t run_free(input longint unsigned addr);
		outcome_t res;
		int i;
		res.ofs = '0;
		for (i = 0; i < blk_cnt; i++)
			if (blk_lo[i] + hdr == addr)
				break;
		if (i >= blk_cnt || !blk_used[i]) begin
			res.stat = STAT_BAD_ADDR;
			return res;
		end
		blk_used[i] = 0;
		if (i + 1 < blk_cnt && !blk_used[i + 1]) begin
			blk_hi[i] = blk_hi[i + 1];
			drop_slot(i + 1);
		end
		if (i > 0 && !blk_used[i - 1]) begin
			blk_hi[i - 1] = blk_hi[i];
			drop_slot(i);
		end
		res.stat = STAT_OK;
		return res;
	endfunction

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			hdr = HDR_RESET;
			blk_cnt = 0;
			heap_built = 0;
			outcome_q.delete();
		end else begin
			if (cfg_wr_en)
				hdr = cfg_wr_data;
			if (in_valid && !in_stall) begin
				if (!heap_built) begin
					blk_lo[0] = 0;
					blk_hi[0] = HEAP;
					blk_used[0] = 0;
					blk_cnt = 1;
					heap_built = 1;
				end
				if (func == FUNC_ALLOC)
					want = run_alloc(req_size);
				else
					want = run_free(address);
				outcome_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("result with no request waiting");
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.stat)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.stat));
					if (payload_offset !== want.ofs)
						report_mismatch($sformatf("offset %0d, expected %0d",
							payload_offset, want.ofs));
				end
			end
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import ffa_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS = 230;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [HDR_W-1:0]  cfg_wr_data;
	logic              in_valid;
	logic              in_stall;
	logic              func;
	logic [ADDR_W-1:0] req_size;
	logic [ADDR_W-1:0] address;
	logic              out_valid;
	logic              out_stall;
	logic [STAT_W-1:0] status;
	logic [ADDR_W-1:0] payload_offset;

	int fail_count;
	int pending;
	int send_idle_pct;
	int stall_pct;
	int quiet_cycles;
	logic [ADDR_W-1:0] granted_q[$];

	first_fit_heap_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .req_size(req_size), .address(address),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .payload_offset(payload_offset)
	);

	heap_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .req_size(req_size), .address(address),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .payload_offset(payload_offset),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
		if (out_valid && !out_stall && status == STAT_OK && payload_offset != 0)
			granted_q.push_back(payload_offset);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_request(input logic f, input logic [ADDR_W-1:0] sz,
			input logic [ADDR_W-1:0] addr);
		bit stalled;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		req_size <= sz;
		address <= addr;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	task automatic write_header(input logic [HDR_W-1:0] value);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	task automatic send_random;
		int pick;
		int idx;
		logic [ADDR_W-1:0] noise;
		noise = ADDR_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 48) begin
			send_request(FUNC_ALLOC, ADDR_W'($urandom_range(0, 3000)), noise);
		end else if (pick < 54) begin
			send_request(FUNC_ALLOC, ADDR_W'($urandom), noise);
		end else if (pick < 86 && granted_q.size() != 0) begin
			idx = $urandom_range(0, granted_q.size() - 1);
			send_request(FUNC_FREE, noise, granted_q[idx]);
			granted_q.delete(idx);
		end else if (pick < 94) begin
			send_request(FUNC_FREE, noise, ADDR_W'($urandom_range(0, 4000)));
		end else begin
			send_request(FUNC_FREE, noise, ADDR_W'($urandom));
		end
	endtask

	initial begin
		logic [HDR_W-1:0] headers[6];
		headers = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd24, 7'd0};
		headers[5] = HDR_W'($urandom_range(1, 64));
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = '0;
		in_valid = 0;
		func = FUNC_ALLOC;
		req_size = '0;
		address = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_request(FUNC_FREE, '0, 21'd24);
		send_request(FUNC_ALLOC, 21'd1048552, '0);
		send_request(FUNC_ALLOC, '0, '0);
		send_request(FUNC_FREE, '1, 21'd24);
		send_request(FUNC_FREE, '0, 21'd24);
		send_request(FUNC_ALLOC, '0, '1);
		send_request(FUNC_ALLOC, 21'd100, '0);
		send_request(FUNC_ALLOC, 21'd200, '0);
		send_request(FUNC_ALLOC, 21'd300, '0);
		send_request(FUNC_FREE, '0, 21'd148);
		send_request(FUNC_FREE, '0, 21'd372);
		send_request(FUNC_FREE, '0, 21'd48);
		send_request(FUNC_FREE, '0, '1);
		send_request(FUNC_ALLOC, '1, '0);
		send_request(FUNC_ALLOC, 21'd1048576, '0);
		send_request(FUNC_FREE, '0, 21'd24);
		send_request(FUNC_FREE, '0, 21'd0);
		for (int i = 0; i < 6; i++)
			send_request(FUNC_ALLOC, 21'd10, '0);

		for (int p = 0; p < 6; p++) begin
			write_header(headers[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 59;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 59;
				end
				default: begin
					send_idle_pct = 36;
					stall_pct = 36;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random();
		end

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
